### hw/rtl/tae_pkg.sv
// ----------------------------------------------------------------------------
// tae_pkg
// Shared widths, register codes and the tap control bundle for the two-tap
// audio echo unit.
// ----------------------------------------------------------------------------
package tae_pkg;

    // payload widths
    localparam int SAMPLE_W   = 16;
    localparam int DELAY_W    = 17;
    localparam int GAIN_W     = 16;
    localparam int SEEN_W     = 18;
    localparam int PROD_W     = SAMPLE_W + GAIN_W;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 4;

    localparam logic [SEEN_W-1:0]   SEEN_MAX   = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY_ONE = 4'd0,
        CFG_DELAY_TWO = 4'd1,
        CFG_GAIN_ONE  = 4'd2,
        CFG_GAIN_TWO  = 4'd3
    } cfg_index_t;

    // per-sample control that travels alongside the history read
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic                act_one;
        logic                act_two;
        logic                fwd_one;
        logic                fwd_two;
    } tap_ctrl_t;

endpackage

### hw/rtl/tae_in_if.sv
// ----------------------------------------------------------------------------
// tae_in_if
// Sample request channel into the echo unit: valid/ready with payload.
// ----------------------------------------------------------------------------
interface tae_in_if;
    import tae_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_in;
    logic                last_sample;

    modport source (output valid, output sample_in, output last_sample, input ready);
    modport sink   (input valid, input sample_in, input last_sample, output ready);

endinterface

### hw/rtl/tae_out_if.sv
// ----------------------------------------------------------------------------
// tae_out_if
// Mixed sample request channel out of the echo unit: valid/ready with payload.
// ----------------------------------------------------------------------------
interface tae_out_if;
    import tae_pkg::*;

    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample_out;
    logic                last_out;

    modport source (output valid, output sample_out, output last_out, input ready);
    modport sink   (input valid, input sample_out, input last_out, output ready);

endinterface

### hw/rtl/tae_ram.sv
// ----------------------------------------------------------------------------
// tae_ram
// Generic RAM: one write port, two read ports, registered read data that
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module tae_ram #(
    parameter int  WIDTH  = 16,
    parameter int  DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [WIDTH-1:0]  rdata_a,
    output logic [WIDTH-1:0]  rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read ports
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

### hw/rtl/tae_ctrl.sv
// ----------------------------------------------------------------------------
// tae_ctrl
// Front stage: takes a sample request, writes it into the history memory,
// issues both tap reads and decides whether each tap contributes.
// ----------------------------------------------------------------------------
module tae_ctrl #(
    parameter int  DELAY_DEPTH = 131072,
    localparam int ADDR_W      = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tae_in_if.sink                      sample_stream,
    input  logic [tae_pkg::DELAY_W-1:0] delay_one,
    input  logic [tae_pkg::DELAY_W-1:0] delay_two,
    output logic                        tap_valid,
    output tae_pkg::tap_ctrl_t          tap,
    input  logic                        tap_ready,
    output logic                        ram_we,
    output logic [ADDR_W-1:0]           ram_waddr,
    output logic [tae_pkg::SAMPLE_W-1:0] ram_wdata,
    output logic                        ram_re,
    output logic [ADDR_W-1:0]           raddr_one,
    output logic [ADDR_W-1:0]           raddr_two
);
    import tae_pkg::*;

    localparam int CALC_W = ((ADDR_W > DELAY_W) ? ADDR_W : DELAY_W) + 2;
    localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(DELAY_DEPTH - 1);

    logic              accept;
    logic [ADDR_W-1:0] ptr_reg, ptr_next;
    logic [SEEN_W-1:0] seen_reg, seen_next;
    logic              tap_valid_reg, tap_valid_next;
    tap_ctrl_t         tap_reg, tap_next;

    // circular read address, delay samples behind the write slot
    function automatic logic [ADDR_W-1:0] back_addr(
        input logic [ADDR_W-1:0]  here,
        input logic [DELAY_W-1:0] delay
    );
        logic [CALC_W-1:0] diff;
        diff = CALC_W'(here) - CALC_W'(delay);
        if (diff[CALC_W-1])
        begin
            diff = diff + CALC_W'(DELAY_DEPTH);
        end
        return diff[ADDR_W-1:0];
    endfunction

    // tap is live once its delay fits the memory and has passed in this buffer
    function automatic logic tap_live(
        input logic [DELAY_W-1:0] delay,
        input logic [SEEN_W-1:0]  seen
    );
        return (CALC_W'(delay) < CALC_W'(DELAY_DEPTH)) && (SEEN_W'(delay) <= seen);
    endfunction

    assign sample_stream.ready = !tap_valid_reg || tap_ready;
    assign accept              = sample_stream.valid && sample_stream.ready;

    // memory write and tap reads issue together with the request
    assign ram_we    = accept;
    assign ram_waddr = ptr_reg;
    assign ram_wdata = sample_stream.sample_in;
    assign ram_re    = accept;
    assign raddr_one = back_addr(ptr_reg, delay_one);
    assign raddr_two = back_addr(ptr_reg, delay_two);

    assign tap_valid = tap_valid_reg;
    assign tap       = tap_reg;

    // next state for pointer, buffer count and the stage register
    always_comb
    begin
        ptr_next       = ptr_reg;
        seen_next      = seen_reg;
        tap_valid_next = tap_valid_reg;
        tap_next       = tap_reg;
        if (tap_ready)
        begin
            tap_valid_next = 1'b0;
        end
        if (accept)
        begin
            ptr_next         = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            tap_valid_next   = 1'b1;
            tap_next.sample  = sample_stream.sample_in;
            tap_next.last    = sample_stream.last_sample;
            tap_next.act_one = tap_live(delay_one, seen_reg);
            tap_next.act_two = tap_live(delay_two, seen_reg);
            // zero delay reads the sample being written this cycle
            tap_next.fwd_one = (delay_one == '0);
            tap_next.fwd_two = (delay_two == '0);
            if (sample_stream.last_sample)
            begin
                seen_next = '0;
            end
            else if (seen_reg != SEEN_MAX)
            begin
                seen_next = seen_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            seen_reg      <= '0;
            tap_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg       <= ptr_next;
            seen_reg      <= seen_next;
            tap_valid_reg <= tap_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        tap_reg <= tap_next;
    end

endmodule

### hw/rtl/tae_mix.sv
// ----------------------------------------------------------------------------
// tae_mix
// Back stages: scales both taps by their gains, saturates the echoes, adds
// them to the dry sample and holds the result in the output register.
// ----------------------------------------------------------------------------
module tae_mix #(
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         tap_valid,
    input  tae_pkg::tap_ctrl_t           tap,
    output logic                         tap_ready,
    input  logic [tae_pkg::SAMPLE_W-1:0] hist_one,
    input  logic [tae_pkg::SAMPLE_W-1:0] hist_two,
    input  logic [tae_pkg::GAIN_W-1:0]   gain_one,
    input  logic [tae_pkg::GAIN_W-1:0]   gain_two,
    tae_out_if.source                    mixed_stream
);
    import tae_pkg::*;

    logic                out_free;
    logic                prod_free;
    logic                prod_valid_reg, prod_valid_next;
    logic [PROD_W-1:0]   prod_one_reg, prod_one_next;
    logic [PROD_W-1:0]   prod_two_reg, prod_two_next;
    logic [SAMPLE_W-1:0] dry_reg, dry_next;
    logic                last_reg, last_next;
    logic [SAMPLE_W-1:0] tap_one_val, tap_two_val;
    logic [SAMPLE_W-1:0] echo_one, echo_two;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] sample_out_reg, sample_out_next;
    logic                last_out_reg, last_out_next;

    // drop the fraction and clamp to full scale
    function automatic logic [SAMPLE_W-1:0] scale_sat(input logic [PROD_W-1:0] prod);
        logic [PROD_W-1:0] whole;
        whole = prod >> GAIN_FRAC_BITS;
        return (|whole[PROD_W-1:SAMPLE_W]) ? SAMPLE_MAX : whole[SAMPLE_W-1:0];
    endfunction

    // stage handshake
    assign out_free  = !out_valid_reg || mixed_stream.ready;
    assign prod_free = !prod_valid_reg || out_free;
    assign tap_ready = prod_free;

    // tap select: forwarded sample for zero delay, else memory data
    assign tap_one_val = tap.fwd_one ? tap.sample : hist_one;
    assign tap_two_val = tap.fwd_two ? tap.sample : hist_two;

    // multiply stage
    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        prod_one_next   = prod_one_reg;
        prod_two_next   = prod_two_reg;
        dry_next        = dry_reg;
        last_next       = last_reg;
        if (prod_free)
        begin
            prod_valid_next = tap_valid;
            if (tap_valid)
            begin
                prod_one_next = tap.act_one ? PROD_W'(tap_one_val) * PROD_W'(gain_one) : '0;
                prod_two_next = tap.act_two ? PROD_W'(tap_two_val) * PROD_W'(gain_two) : '0;
                dry_next      = tap.sample;
                last_next     = tap.last;
            end
        end
    end

    assign echo_one = scale_sat(prod_one_reg);
    assign echo_two = scale_sat(prod_two_reg);

    // sum stage into the output register, wrapping at 16 bits
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        sample_out_next = sample_out_reg;
        last_out_next   = last_out_reg;
        if (out_free)
        begin
            out_valid_next = prod_valid_reg;
            if (prod_valid_reg)
            begin
                sample_out_next = dry_reg + echo_one + echo_two;
                last_out_next   = last_reg;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_one_reg   <= prod_one_next;
        prod_two_reg   <= prod_two_next;
        dry_reg        <= dry_next;
        last_reg       <= last_next;
        sample_out_reg <= sample_out_next;
        last_out_reg   <= last_out_next;
    end

    assign mixed_stream.valid      = out_valid_reg;
    assign mixed_stream.sample_out = sample_out_reg;
    assign mixed_stream.last_out   = last_out_reg;

endmodule

### hw/rtl/two_tap_audio_echo_unit.sv
// ----------------------------------------------------------------------------
// two_tap_audio_echo_unit
// A request accepted at a clock edge has its history read at that edge, then
// passes the multiply register and the sum into the output register before
// it is offered. Throughput: one sample per cycle while results are taken;
// the two-read, one-write history RAM serves both taps and the store of the
// new sample in the same cycle. Reset clears pointer, buffer count, config
// registers and valids; the history RAM is not cleared, taps only read
// entries written in the current buffer.
// ----------------------------------------------------------------------------
module two_tap_audio_echo_unit #(
    parameter int DELAY_DEPTH    = 131072,
    parameter int GAIN_FRAC_BITS = 15
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tae_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tae_pkg::CFG_DATA_W-1:0] cfg_data,
    tae_in_if.sink                         sample_stream,
    tae_out_if.source                      mixed_stream
);
    import tae_pkg::*;

    localparam int ADDR_W = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;

    logic [DELAY_W-1:0]  delay_one_reg, delay_two_reg;
    logic [GAIN_W-1:0]   gain_one_reg, gain_two_reg;

    logic                tap_valid;
    logic                tap_ready;
    tap_ctrl_t           tap;
    logic                ram_we;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]   raddr_one, raddr_two;
    logic [SAMPLE_W-1:0] hist_one, hist_two;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            gain_one_reg  <= '0;
            gain_two_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DELAY_ONE: delay_one_reg <= cfg_data[DELAY_W-1:0];
                CFG_DELAY_TWO: delay_two_reg <= cfg_data[DELAY_W-1:0];
                CFG_GAIN_ONE:  gain_one_reg  <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_TWO:  gain_two_reg  <= cfg_data[GAIN_W-1:0];
                default:       ;
            endcase
        end
    end

    // front stage: write, tap reads, tap activity
    tae_ctrl #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_stream (sample_stream),
        .delay_one     (delay_one_reg),
        .delay_two     (delay_two_reg),
        .tap_valid     (tap_valid),
        .tap           (tap),
        .tap_ready     (tap_ready),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .raddr_one     (raddr_one),
        .raddr_two     (raddr_two)
    );

    // sample history
    tae_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DELAY_DEPTH)
    ) u_history (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re      (ram_re),
        .raddr_a (raddr_one),
        .raddr_b (raddr_two),
        .rdata_a (hist_one),
        .rdata_b (hist_two)
    );

    // gain, saturate, sum, output register
    tae_mix #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_mix (
        .clk          (clk),
        .rst_n        (rst_n),
        .tap_valid    (tap_valid),
        .tap          (tap),
        .tap_ready    (tap_ready),
        .hist_one     (hist_one),
        .hist_two     (hist_two),
        .gain_one     (gain_one_reg),
        .gain_two     (gain_two_reg),
        .mixed_stream (mixed_stream)
    );

endmodule

### hw/rtl/tae_checker.sv
// ----------------------------------------------------------------------------
// tae_checker
// Port-level checks on the echo unit: reset, stall cause, hold under
// backpressure and fill latency.
// ----------------------------------------------------------------------------
module tae_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [tae_pkg::SAMPLE_W-1:0] sample_out,
    input logic                         last_out
);

    // no result is offered while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("output valid during reset");

    // the input only stalls behind a result that is not taken
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // a result that is not taken holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(sample_out) && $stable(last_out)))
        else $error("result changed while stalled");

    // with the output draining, a taken request is offered after the tap, product and output registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready |=> out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind two_tap_audio_echo_unit tae_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_stream.valid),
    .in_ready   (sample_stream.ready),
    .out_valid  (mixed_stream.valid),
    .out_ready  (mixed_stream.ready),
    .sample_out (mixed_stream.sample_out),
    .last_out   (mixed_stream.last_out)
);

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-tap audio echo unit. A directed table runs
// first: reset values, zero-delay taps, wrap of the sum, saturation of the
// tap product, masked and ignored register writes, and tap gating inside a
// buffer. Random buffers follow under several tap settings, then two buffers
// with the longest delay on the first tap. Every result is compared with
// an in-order queue that a built-in echo predictor fills.
// ----------------------------------------------------------------------------
module tb_top;
    import tae_pkg::*;

    localparam int DEPTH       = 131072;
    localparam int FRAC        = 15;
    localparam int IDLE_PCT    = 8;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_LEN   = 80;
    localparam int NUM_PHASES  = 6;
    localparam int PLAN_LEN    = 26;

    localparam logic [DELAY_W-1:0]    DELAY_MAX = '1;
    localparam logic [CFG_IDX_W-1:0]  CFG_SPARE = '1;
    localparam logic [CFG_DATA_W-1:0] DATA_ALL  = '1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } mix_t;

    typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [SAMPLE_W-1:0]    smp;
        logic                   lst;
        bit                     typed;
        logic [SAMPLE_W-1:0]    typed_out;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tae_in_if  sample_if ();
    tae_out_if mixed_if ();

    // predictor state
    logic [DELAY_W-1:0]  dly_one   = '0;
    logic [DELAY_W-1:0]  dly_two   = '0;
    logic [GAIN_W-1:0]   gain_one  = '0;
    logic [GAIN_W-1:0]   gain_two  = '0;
    bit   [SAMPLE_W-1:0] hist [DEPTH];
    logic [DELAY_W-1:0]  wr_ptr    = '0;
    logic [SEEN_W-1:0]   buf_seen  = '0;

    mix_t pending_mix [$];
    int   fail_count   = 0;
    bit   source_quiet = 1'b0;
    bit   sink_quiet   = 1'b0;

    // directed table: typed results only where they follow at a glance
    plan_row_t directed_plan [PLAN_LEN] = '{
        '{ROW_SAMPLE, '0, '0, 16'h0000, 1'b0, 1'b1, 16'h0000},
        '{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, 1'b1, 16'hFFFF},
        '{ROW_SAMPLE, '0, '0, 16'h8001, 1'b1, 1'b1, 16'h8001},
        '{ROW_CFG, CFG_GAIN_ONE, 17'h08000, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h1234, 1'b0, 1'b1, 16'h2468},
        '{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b1, 1'b1, 16'hFFFE},
        '{ROW_CFG, CFG_GAIN_ONE, 17'h1FFFF, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'hC000, 1'b1, 1'b1, 16'hBFFF},
        '{ROW_CFG, CFG_SPARE, 17'h1FFFF, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h0001, 1'b1, 1'b1, 16'h0002},
        '{ROW_CFG, CFG_DELAY_ONE, 17'd3, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_ONE, 17'h08000, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_DELAY_TWO, 17'd5, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_TWO, 17'h04000, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h1000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h2000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h3000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h4000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h5000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h6000, 1'b1, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h7000, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'h8000, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_DELAY_TWO, 17'h1FFFF, '0, 1'b0, 1'b0, '0},
        '{ROW_CFG, CFG_GAIN_TWO, 17'h0FFFF, '0, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b0, 1'b0, '0},
        '{ROW_SAMPLE, '0, '0, 16'hFFFF, 1'b1, 1'b0, '0}
    };

    two_tap_audio_echo_unit #(
        .DELAY_DEPTH    (DEPTH),
        .GAIN_FRAC_BITS (FRAC)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .sample_stream (sample_if),
        .mixed_stream  (mixed_if)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one echo tap: silent if its delay does not fit the memory or has not yet passed inside the buffer
    function automatic logic [SAMPLE_W-1:0] tap_echo(input logic [DELAY_W-1:0] dly,
                                                     input logic [GAIN_W-1:0] gain);
        int                addr;
        logic [PROD_W-1:0] prod;
        if (dly >= DEPTH || buf_seen < dly)
            return '0;
        addr = (int'(wr_ptr) + DEPTH - int'(dly)) % DEPTH;
        prod = (PROD_W'(hist[addr]) * PROD_W'(gain)) >> FRAC;
        if (prod > PROD_W'(SAMPLE_MAX))
            return SAMPLE_MAX;
        return prod[SAMPLE_W-1:0];
    endfunction

    // store the sample, mix both taps, advance pointer and buffer count
    function automatic mix_t echo_mix(input logic [SAMPLE_W-1:0] smp, input logic lst);
        mix_t res;
        hist[wr_ptr] = smp;
        res.sample = smp + tap_echo(dly_one, gain_one) + tap_echo(dly_two, gain_two);
        res.last   = lst;
        wr_ptr = DELAY_W'((int'(wr_ptr) + 1) % DEPTH);
        if (lst)
            buf_seen = '0;
        else if (buf_seen != SEEN_MAX)
            buf_seen = buf_seen + 1'b1;
        return res;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return '0;
            1: return SAMPLE_MAX;
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        case ($urandom_range(9))
            7: return CFG_DATA_W'($urandom_range(0, int'(DELAY_MAX)));
            8: return DELAY_MAX;
            9: return '0;
            default: return CFG_DATA_W'($urandom_range(0, 24));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(5))
            0: return '0;
            1: return CFG_DATA_W'(17'h08000);
            2: return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(0, int'(SAMPLE_MAX)));
        endcase
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // register write, mirrored into the predictor
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_DELAY_ONE: dly_one  = data[DELAY_W-1:0];
            CFG_DELAY_TWO: dly_two  = data[DELAY_W-1:0];
            CFG_GAIN_ONE:  gain_one = data[GAIN_W-1:0];
            CFG_GAIN_TWO:  gain_two = data[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    // drop valid and wait until every pending result has come back
    task automatic settle();
        @(negedge clk);
        sample_if.valid <= 1'b0;
        while (pending_mix.size() != 0)
            @(posedge clk);
    endtask

    // one sample request, with random gaps ahead of it
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic lst,
                               input bit typed, input logic [SAMPLE_W-1:0] typed_out);
        mix_t want;
        @(negedge clk);
        while (!source_quiet && $urandom_range(99) < IDLE_PCT)
        begin
            sample_if.valid <= 1'b0;
            @(negedge clk);
        end
        sample_if.valid       <= 1'b1;
        sample_if.sample_in   <= smp;
        sample_if.last_sample <= lst;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        want = echo_mix(smp, lst);
        if (typed)
            want.sample = typed_out;
        pending_mix.push_back(want);
    endtask

    // result side back-pressure
    always @(negedge clk)
    begin
        mixed_if.ready <= sink_quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each mixed sample with the oldest expectation
    always @(posedge clk)
    begin : result_check
        mix_t want;
        if (rst_n && mixed_if.valid && mixed_if.ready)
        begin
            if (pending_mix.size() == 0)
            begin
                note_mismatch($sformatf("unexpected result sample=%h last=%b",
                                        mixed_if.sample_out, mixed_if.last_out));
            end
            else
            begin
                want = pending_mix.pop_front();
                if (mixed_if.sample_out !== want.sample)
                    note_mismatch($sformatf("sample_out %h, expected %h",
                                            mixed_if.sample_out, want.sample));
                if (mixed_if.last_out !== want.last)
                    note_mismatch($sformatf("last_out %b, expected %b",
                                            mixed_if.last_out, want.last));
            end
        end
    end

    // watchdog on cycles with no request moving on either side
    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((sample_if.valid && sample_if.ready) || (mixed_if.valid && mixed_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int i;
        int k;
        int phase;
        int sent;
        int len;
        logic [CFG_DATA_W-1:0] d_one;
        logic [CFG_DATA_W-1:0] d_two;
        logic [CFG_DATA_W-1:0] g_one;
        logic [CFG_DATA_W-1:0] g_two;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        sample_if.valid       = 1'b0;
        sample_if.sample_in   = '0;
        sample_if.last_sample = 1'b0;
        mixed_if.ready        = 1'b0;

        // reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        for (i = 0; i < PLAN_LEN; i++)
        begin
            if (directed_plan[i].kind == ROW_CFG)
            begin
                settle();
                cfg_write(directed_plan[i].idx, directed_plan[i].data);
            end
            else
            begin
                send_sample(directed_plan[i].smp, directed_plan[i].lst,
                            directed_plan[i].typed, directed_plan[i].typed_out);
            end
        end

        // random buffers under several tap settings
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            d_one = pick_delay();
            d_two = pick_delay();
            g_one = pick_gain();
            g_two = pick_gain();
            if (phase == 1)
            begin
                g_one = DATA_ALL;
                g_two = CFG_DATA_W'(SAMPLE_MAX);
            end
            if (phase == 2)
            begin
                d_one = '0;
                d_two = DELAY_MAX;
                g_one = '0;
            end
            cfg_write(CFG_DELAY_ONE, d_one);
            cfg_write(CFG_DELAY_TWO, d_two);
            cfg_write(CFG_GAIN_ONE, g_one);
            cfg_write(CFG_GAIN_TWO, g_two);
            cfg_write(CFG_IDX_W'($urandom_range(int'(CFG_GAIN_TWO) + 1, int'(CFG_SPARE))),
                      CFG_DATA_W'($urandom()));
            // no idling on either side in phase 2, and none on the result side in phase 4
            source_quiet = (phase == 2);
            sink_quiet   = (phase == 2) || (phase == 4);

            sent = 0;
            while (sent < PHASE_LEN)
            begin
                // mostly full buffers, some cut short before the taps open
                if ($urandom_range(99) < 85)
                    len = $urandom_range(1, 48);
                else
                    len = $urandom_range(1, 4);
                for (k = 0; k < len; k++)
                    send_sample(pick_sample(), (k == len - 1), 1'b0, '0);
                sent += len;
            end
        end

        // two buffers with the longest delay on the first tap
        settle();
        source_quiet = 1'b0;
        sink_quiet   = 1'b0;
        cfg_write(CFG_DELAY_ONE, DELAY_MAX);
        cfg_write(CFG_DELAY_TWO, CFG_DATA_W'($urandom_range(1, 24)));
        cfg_write(CFG_GAIN_ONE, pick_gain());
        cfg_write(CFG_GAIN_TWO, pick_gain());
        for (i = 0; i < 24; i++)
            send_sample(pick_sample(), 1'b0, 1'b0, '0);
        send_sample(pick_sample(), 1'b1, 1'b0, '0);
        for (k = 0; k < 8; k++)
            send_sample(pick_sample(), (k == 7), 1'b0, '0);

        // drain and finish
        settle();
        repeat (10) @(posedge clk);
        if (pending_mix.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_mix.size()));
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
